[design/rtcrf_pkg.sv]
package rtcrf_pkg;

	localparam int REGISTER_COUNT_DEF = 18;
	localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h68;
	localparam logic [7:0] PM_FLAG = 8'h20;
	localparam logic [3:0] REG_ADDR_DEVICE = 4'd0;

	typedef enum logic [1:0] {
		KIND_EMPTY   = 2'd0,
		KIND_POINTER = 2'd1,
		KIND_WRITE   = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        starts_transaction;
		logic [6:0]  dev_addr;
		logic [7:0]  write_byte;
		logic [5:0]  clock_minute;
		logic [4:0]  clock_hour;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       addr_error;
	} result_t;

endpackage

[design/rtcrf_time_enc.sv]
module rtcrf_time_enc (
	input  logic [5:0] clock_minute,
	input  logic [4:0] clock_hour,
	output logic [7:0] minute_bcd,
	output logic [7:0] hour_bcd
);

	logic [3:0] min_tens;
	logic [5:0] min_ones;
	logic [4:0] hour_mod;
	logic [3:0] hour_12;
	logic       pm;

	// minute tens by range compare, ones by subtract
	always_comb begin
		if (clock_minute >= 6'd60) begin
			min_tens = 4'd6;
			min_ones = clock_minute - 6'd60;
		end else if (clock_minute >= 6'd50) begin
			min_tens = 4'd5;
			min_ones = clock_minute - 6'd50;
		end else if (clock_minute >= 6'd40) begin
			min_tens = 4'd4;
			min_ones = clock_minute - 6'd40;
		end else if (clock_minute >= 6'd30) begin
			min_tens = 4'd3;
			min_ones = clock_minute - 6'd30;
		end else if (clock_minute >= 6'd20) begin
			min_tens = 4'd2;
			min_ones = clock_minute - 6'd20;
		end else if (clock_minute >= 6'd10) begin
			min_tens = 4'd1;
			min_ones = clock_minute - 6'd10;
		end else begin
			min_tens = 4'd0;
			min_ones = clock_minute;
		end
	end

	assign minute_bcd = {min_tens, min_ones[3:0]};

	// 12-hour form, hours past 23 count as pm
	always_comb begin
		pm = (clock_hour >= 5'd12);
		if (clock_hour >= 5'd24) begin
			hour_mod = clock_hour - 5'd24;
		end else if (clock_hour >= 5'd12) begin
			hour_mod = clock_hour - 5'd12;
		end else begin
			hour_mod = clock_hour;
		end
		hour_12 = (hour_mod == 5'd0) ? 4'd12 : hour_mod[3:0];
		if (hour_12 >= 4'd10) begin
			hour_bcd = {4'd1, hour_12 - 4'd10};
		end else begin
			hour_bcd = {4'd0, hour_12};
		end
		if (pm) begin
			hour_bcd = hour_bcd | rtcrf_pkg::PM_FLAG;
		end
	end

endmodule

[design/rtcrf_core.sv]
module rtcrf_core #(
	parameter int REGISTER_COUNT = rtcrf_pkg::REGISTER_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rtcrf_pkg::item_t   item,
	input  logic [6:0]         device_address,
	output rtcrf_pkg::result_t result
);

	localparam int IDX_W = $clog2(REGISTER_COUNT);
	localparam logic [8:0] COUNT_9 = 9'(REGISTER_COUNT);

	logic [7:0] file_q [REGISTER_COUNT];
	logic [7:0] pointer_q;

	logic [7:0] minute_bcd;
	logic [7:0] hour_bcd;
	logic       match;
	logic       in_range;
	logic [8:0] ptr_inc;
	logic       wraps;
	logic       refresh;
	logic       wr_en;
	logic [7:0] pointer_d;
	logic [7:0] file_rd;

	rtcrf_time_enc u_time_enc (
		.clock_minute (item.clock_minute),
		.clock_hour   (item.clock_hour),
		.minute_bcd   (minute_bcd),
		.hour_bcd     (hour_bcd)
	);

	assign match    = (item.dev_addr == device_address);
	assign in_range = ({1'b0, pointer_q} < COUNT_9);
	assign ptr_inc  = {1'b0, pointer_q} + 9'd1;
	assign wraps    = (ptr_inc >= COUNT_9);
	assign file_rd  = file_q[pointer_q[IDX_W-1:0]];

	always_comb begin
		refresh   = 1'b0;
		wr_en     = 1'b0;
		pointer_d = pointer_q;
		result.read_data  = 8'd0;
		result.addr_error = !match;
		if (match) begin
			case (item.kind)
				rtcrf_pkg::KIND_EMPTY: begin
					refresh = 1'b1;
				end
				rtcrf_pkg::KIND_POINTER: begin
					refresh   = 1'b1;
					pointer_d = item.write_byte;
				end
				rtcrf_pkg::KIND_WRITE: begin
					wr_en     = in_range;
					refresh   = wraps;
					pointer_d = wraps ? 8'd0 : ptr_inc[7:0];
				end
				default: begin
					// read sees a refresh done at transaction start
					if (in_range) begin
						if (item.starts_transaction && pointer_q == 8'd1) begin
							result.read_data = minute_bcd;
						end else if (item.starts_transaction && pointer_q == 8'd2) begin
							result.read_data = hour_bcd;
						end else begin
							result.read_data = file_rd;
						end
					end
					refresh   = wraps || item.starts_transaction;
					pointer_d = wraps ? 8'd0 : ptr_inc[7:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_q <= 8'd0;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				file_q[i] <= 8'd0;
			end
		end else if (step) begin
			pointer_q <= pointer_d;
			for (int i = 0; i < REGISTER_COUNT; i++) begin
				if (refresh && i == 1) begin
					file_q[i] <= minute_bcd;
				end else if (refresh && i == 2) begin
					file_q[i] <= hour_bcd;
				end else if (wr_en && pointer_q[IDX_W-1:0] == IDX_W'(i)) begin
					file_q[i] <= item.write_byte;
				end
			end
		end
	end

endmodule

[design/rtc_register_file_slave.sv]
// rtc register file slave: one bus byte per transfer, one result per byte
// path: a byte is held in the input register, then passes the core into the result register; out_stall can hold it
// throughput: one byte per cycle while out_stall is low; the register file and pointer update in one pass
// reset: asynchronous arst_n clears the register file and pointer to zero and
// loads the device address 0x68; no clearing pass, a byte may follow reset at once
module rtc_register_file_slave #(
	parameter int REGISTER_COUNT = rtcrf_pkg::REGISTER_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic        starts_transaction,
	input  logic [6:0]  dev_addr,
	input  logic [7:0]  write_byte,
	input  logic [5:0]  clock_minute,
	input  logic [4:0]  clock_hour,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        addr_error,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic               valid_s1;
	rtcrf_pkg::item_t   item_s1;
	logic               out_valid_q;
	logic [7:0]         read_data_q;
	logic               addr_error_q;
	logic [6:0]         device_address_q;
	logic               step;
	logic               load;
	logic               dev_reg_sel;
	rtcrf_pkg::result_t result;

	// register index from the word address
	assign dev_reg_sel = ({1'b0, paddr[2]} == rtcrf_pkg::REG_ADDR_DEVICE[1:0]);

	// apb: no wait states, single device address register
	assign pready = 1'b1;
	assign prdata = dev_reg_sel ? {25'd0, device_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= rtcrf_pkg::DEVICE_ADDRESS_RST;
		end else if (psel && penable && pwrite && pready && dev_reg_sel) begin
			device_address_q <= pwdata[6:0];
		end
	end

	// the held byte is processed when the result register is free or draining
	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign load     = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.kind               <= rtcrf_pkg::kind_t'(kind);
			item_s1.starts_transaction <= starts_transaction;
			item_s1.dev_addr           <= dev_addr;
			item_s1.write_byte         <= write_byte;
			item_s1.clock_minute       <= clock_minute;
			item_s1.clock_hour         <= clock_hour;
		end
	end

	// register file, pointer and time encoding
	rtcrf_core #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.item           (item_s1),
		.device_address (device_address_q),
		.result         (result)
	);

	// result register, holds until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			read_data_q  <= result.read_data;
			addr_error_q <= result.addr_error;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign addr_error = addr_error_q;

endmodule

[bench/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REG_COUNT = rtcrf_pkg::REGISTER_COUNT_DEF;
	localparam logic [2:0] DEVICE_ADDR_PADDR = 3'(rtcrf_pkg::REG_ADDR_DEVICE);

	// receiver behavior on the result channel
	typedef enum int {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic        starts_transaction;
	logic [6:0]  dev_addr;
	logic [7:0]  write_byte;
	logic [5:0]  clock_minute;
	logic [4:0]  clock_hour;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        addr_error;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	rtc_register_file_slave uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.starts_transaction (starts_transaction),
		.dev_addr           (dev_addr),
		.write_byte         (write_byte),
		.clock_minute       (clock_minute),
		.clock_hour         (clock_hour),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.read_data          (read_data),
		.addr_error         (addr_error),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the slave: register file, pointer and bus address
	logic [7:0] shadow_regs [REG_COUNT];
	logic [7:0] shadow_ptr;
	logic [6:0] shadow_dev;

	// results still owed by the slave, oldest first
	rtcrf_pkg::result_t pending_results [$];

	int mismatch_count = 0;
	int items_sent = 0;

	// sender idling: bursts of transfers separated by gaps
	bit tx_idle_en = 1'b0;
	int burst_left = 0;

	// receiver idling and the long hold-off
	rx_mode_t   rx_mode = RX_FREE;
	bit         hold_start = 1'b0;
	int         hold_len = 0;
	int         hold_left = 0;
	logic [7:0] stall_pattern = 8'b0110_0010;
	int         pattern_age = 0;

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// 24-hour value to 12-hour bcd, pm flag for hour 12 and above
	function automatic logic [7:0] hour_12h_code(input logic [4:0] h24);
		int unsigned h;
		logic [7:0] pm;
		h = h24 % 12;
		if (h == 0)
			h = 12;
		pm = (h24 >= 5'd12) ? rtcrf_pkg::PM_FLAG : 8'h00;
		return pm | to_bcd(h);
	endfunction

	task automatic load_time(input rtcrf_pkg::item_t it);
		shadow_regs[1] = to_bcd(it.clock_minute);
		shadow_regs[2] = hour_12h_code(it.clock_hour);
	endtask

	// auto-increment; running off the end wraps to 0 and reloads the time
	task automatic step_pointer(input rtcrf_pkg::item_t it);
		int unsigned nxt;
		nxt = shadow_ptr + 1;
		if (nxt >= REG_COUNT) begin
			shadow_ptr = '0;
			load_time(it);
		end else begin
			shadow_ptr = nxt[7:0];
		end
	endtask

	task automatic predict_bus_byte(input rtcrf_pkg::item_t it);
		rtcrf_pkg::result_t r;
		r = '0;
		if (it.dev_addr != shadow_dev) begin
			// foreign address: flag only, state untouched
			r.addr_error = 1'b1;
		end else begin
			case (it.kind)
				rtcrf_pkg::KIND_EMPTY: begin
					load_time(it);
				end
				rtcrf_pkg::KIND_POINTER: begin
					load_time(it);
					shadow_ptr = it.write_byte;
				end
				rtcrf_pkg::KIND_WRITE: begin
					if (shadow_ptr < REG_COUNT)
						shadow_regs[shadow_ptr] = it.write_byte;
					step_pointer(it);
				end
				default: begin
					if (it.starts_transaction)
						load_time(it);
					if (shadow_ptr < REG_COUNT)
						r.read_data = shadow_regs[shadow_ptr];
					step_pointer(it);
				end
			endcase
		end
		pending_results.push_back(r);
	endtask

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		rtcrf_pkg::result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result with nothing expected: read_data %02h addr_error %0b",
					read_data, addr_error));
			end else begin
				want = pending_results.pop_front();
				if (read_data !== want.read_data)
					flag_error($sformatf("read_data: expected %02h, got %02h",
						want.read_data, read_data));
				if (addr_error !== want.addr_error)
					flag_error($sformatf("addr_error: expected %0b, got %0b",
						want.addr_error, addr_error));
			end
		end
	end

	// ---------------------------------------------------------------
	// result receiver: free, random or rotating pattern, plus hold-off
	// ---------------------------------------------------------------

	always @(negedge clk) begin
		if (hold_start) begin
			hold_left = hold_len;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			// long hold-off, counted down one cycle at a time
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_RANDOM: begin
					out_stall <= ($urandom_range(99) < 35);
				end
				RX_PATTERN: begin
					out_stall <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
					pattern_age++;
					if (pattern_age == 32) begin
						pattern_age = 0;
						stall_pattern = 8'($urandom_range(255));
					end
				end
				default: begin
					out_stall <= 1'b0;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------

	// one bus byte: present at the falling edge, hold until accepted
	task automatic send_byte(input rtcrf_pkg::item_t it);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= it.kind;
		starts_transaction <= it.starts_transaction;
		dev_addr <= it.dev_addr;
		write_byte <= it.write_byte;
		clock_minute <= it.clock_minute;
		clock_hour <= it.clock_hour;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predict_bus_byte(it);
		items_sent++;
		if (tx_idle_en) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// stop offering and wait for every owed result
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// time fields mostly in range, sometimes anywhere the widths allow
	function automatic rtcrf_pkg::item_t timed_item(input rtcrf_pkg::kind_t k, input logic st,
		input logic [6:0] a, input logic [7:0] b);
		rtcrf_pkg::item_t it;
		it.kind = k;
		it.starts_transaction = st;
		it.dev_addr = a;
		it.write_byte = b;
		if ($urandom_range(99) < 85) begin
			it.clock_minute = 6'($urandom_range(59));
			it.clock_hour = 5'($urandom_range(23));
		end else begin
			it.clock_minute = 6'($urandom_range(63));
			it.clock_hour = 5'($urandom_range(31));
		end
		return it;
	endfunction

	function automatic rtcrf_pkg::item_t fixed_time(input rtcrf_pkg::item_t it,
		input logic [5:0] m, input logic [4:0] h);
		rtcrf_pkg::item_t r;
		r = it;
		r.clock_minute = m;
		r.clock_hour = h;
		return r;
	endfunction

	function automatic logic [6:0] pick_dev();
		if ($urandom_range(9) != 0)
			return shadow_dev;
		return 7'($urandom_range(127));
	endfunction

	// pointer mostly inside the file, some near the end, a few anywhere
	function automatic logic [7:0] pick_pointer();
		int r;
		r = $urandom_range(9);
		if (r < 7)
			return 8'($urandom_range(REG_COUNT - 1));
		if (r < 9)
			return 8'($urandom_range(REG_COUNT - 3, REG_COUNT + 2));
		return 8'($urandom_range(255));
	endfunction

	// well-formed write and read transactions with random content, plus noise
	task automatic run_traffic(input int n);
		int stop_at;
		int r;
		int len;
		logic [6:0] a;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			r = $urandom_range(99);
			a = pick_dev();
			if (r < 40) begin
				send_byte(timed_item(rtcrf_pkg::KIND_POINTER, 1'($urandom_range(1)), a,
					pick_pointer()));
				len = $urandom_range(6);
				repeat (len)
					send_byte(timed_item(rtcrf_pkg::KIND_WRITE, 1'($urandom_range(1)), a,
						8'($urandom_range(255))));
			end else if (r < 80) begin
				if ($urandom_range(9) < 7)
					send_byte(timed_item(rtcrf_pkg::KIND_POINTER, 1'($urandom_range(1)), a,
						pick_pointer()));
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					send_byte(timed_item(rtcrf_pkg::KIND_READ,
						(i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0),
						a, 8'($urandom_range(255))));
			end else if (r < 88) begin
				send_byte(timed_item(rtcrf_pkg::KIND_EMPTY, 1'($urandom_range(1)), a,
					8'($urandom_range(255))));
			end else begin
				// noise: any kind, any address
				send_byte(timed_item(rtcrf_pkg::kind_t'($urandom_range(3)),
					1'($urandom_range(1)), 7'($urandom_range(127)),
					8'($urandom_range(255))));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= DEVICE_ADDR_PADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_device_address();
		logic [31:0] rd;
		apb_access(1'b0, 32'h0, rd);
		if (rd[6:0] !== shadow_dev)
			flag_error($sformatf("device address readback: expected %02h, got %02h",
				shadow_dev, rd[6:0]));
	endtask

	// only called with the slave idle; upper data bits are don't-care
	task automatic configure_device_address(input logic [6:0] v);
		logic [31:0] rd;
		apb_access(1'b1, {25'($urandom), v}, rd);
		shadow_dev = v;
		check_device_address();
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset address, and registers 0 and 1 read back zero before any reload
	task automatic test_after_reset();
		check_device_address();
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'hFF));
		wait_drained();
	endtask

	// minute and hour encodings, including out-of-range time values
	task automatic test_time_codes();
		logic [5:0] mins [4] = '{6'd0, 6'd59, 6'd63, 6'd9};
		logic [4:0] hours [4] = '{5'd0, 5'd12, 5'd31, 5'd23};
		for (int i = 0; i < 4; i++) begin
			send_byte(fixed_time(timed_item(rtcrf_pkg::KIND_POINTER, 1'b0, shadow_dev, 8'd1),
				mins[i], hours[i]));
			send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
			send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
		end
		wait_drained();
	endtask

	// foreign address, wrap past the last register, pointer beyond the file
	task automatic test_wrap_and_errors();
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b1, shadow_dev ^ 7'h55, 8'h00));
		// write to the last register wraps and reloads the time
		send_byte(timed_item(rtcrf_pkg::KIND_POINTER, 1'b0, shadow_dev, 8'(REG_COUNT - 1)));
		send_byte(fixed_time(timed_item(rtcrf_pkg::KIND_WRITE, 1'b0, shadow_dev, 8'hA5),
			6'd37, 5'd15));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
		// write at pointer 255 is dropped and wraps
		send_byte(timed_item(rtcrf_pkg::KIND_POINTER, 1'b0, shadow_dev, 8'hFF));
		send_byte(timed_item(rtcrf_pkg::KIND_WRITE, 1'b1, shadow_dev, 8'h3C));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b1, shadow_dev, 8'h00));
		// read just past the file gives zero
		send_byte(timed_item(rtcrf_pkg::KIND_POINTER, 1'b1, shadow_dev, 8'(REG_COUNT)));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b0, shadow_dev, 8'h00));
		send_byte(timed_item(rtcrf_pkg::KIND_EMPTY, 1'b0, shadow_dev, 8'h00));
		send_byte(timed_item(rtcrf_pkg::KIND_READ, 1'b1, shadow_dev, 8'h00));
		wait_drained();
	endtask

	// back-to-back transfers, no idling on either side
	task automatic test_steady_stream();
		tx_idle_en = 1'b0;
		rx_mode = RX_FREE;
		run_traffic(60);
		wait_drained();
	endtask

	// receiver holds off while the sender keeps offering, then the sender drains
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_mode = RX_FREE;
		hold_len = 40;
		hold_start = 1'b1;
		run_traffic(24);
		wait_drained();
	endtask

	// traffic under several bus addresses, extremes included
	task automatic test_device_address();
		logic [6:0] addrs [4];
		addrs = '{7'h00, 7'h7F, 7'($urandom_range(1, 126)), rtcrf_pkg::DEVICE_ADDRESS_RST};
		tx_idle_en = 1'b1;
		for (int i = 0; i < 4; i++) begin
			rx_mode = (i % 2 == 0) ? RX_RANDOM : RX_PATTERN;
			configure_device_address(addrs[i]);
			run_traffic(80);
			wait_drained();
		end
	endtask

	// mixed idling with a full drain in the middle
	task automatic test_mixed_idle();
		tx_idle_en = 1'b1;
		rx_mode = RX_PATTERN;
		run_traffic(25);
		wait_drained();
		rx_mode = RX_RANDOM;
		run_traffic(25);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = rtcrf_pkg::KIND_EMPTY;
		starts_transaction = 1'b0;
		dev_addr = '0;
		write_byte = '0;
		clock_minute = '0;
		clock_hour = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < REG_COUNT; i++)
			shadow_regs[i] = 8'h00;
		shadow_ptr = 8'h00;
		shadow_dev = rtcrf_pkg::DEVICE_ADDRESS_RST;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		tx_idle_en = 1'b1;
		rx_mode = RX_RANDOM;
		test_after_reset();
		test_time_codes();
		test_wrap_and_errors();
		test_steady_stream();
		test_backpressure();
		test_device_address();
		test_mixed_idle();

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS rtc_register_file_slave");
		else
			$display("FAIL rtc_register_file_slave");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#1ms;
		$display("FAIL rtc_register_file_slave");
		$finish;
	end

endmodule
